// ===== sv/ptm_pkg.sv =====
// Shared types, request codes and the expiry helper function of the priority TTL mailbox.
package ptm_pkg;

	// Request codes carried on req_type.
	localparam logic [2:0] REQ_REG   = 3'd0;
	localparam logic [2:0] REQ_UNREG = 3'd1;
	localparam logic [2:0] REQ_SEND  = 3'd2;
	localparam logic [2:0] REQ_RECV  = 3'd3;
	localparam logic [2:0] REQ_BCAST = 3'd4;
	localparam logic [2:0] REQ_COUNT = 3'd5;

	// Result status codes.
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	// Priority given to broadcast messages.
	localparam logic [1:0] PRIO_NORMAL = 2'd1;

	// One stored message.
	typedef struct packed {
		logic [7:0]  kind;
		logic [63:0] sender;
		logic [63:0] corr;
		logic [31:0] payload;
		logic [15:0] bytes;
		logic [31:0] stamp;
		logic [1:0]  prio;
		logic [31:0] ttl;
	} entry_t;

	// Operations the controller asks of the datapath.
	typedef enum logic [3:0] {
		OP_IDLE,
		OP_LOAD,
		OP_SLOT_SCAN,
		OP_REG,
		OP_UNREG,
		OP_SEND,
		OP_COUNT,
		OP_BAD,
		OP_BCAST_STEP,
		OP_RX_START,
		OP_RX_STEP,
		OP_RX_FIN,
		OP_FINISH
	} op_t;

	// Status the datapath reports back to the controller.
	typedef struct packed {
		logic [2:0] req;
		logic       found;
		logic       scan_last;
		logic       rx_done;
		logic       out_busy;
	} stat_t;

	// A message has expired once its lifetime, counted from its stamp, is over.
	function automatic logic expired(input entry_t e, input logic [31:0] now);
		logic [32:0] limit;
		limit = {1'b0, e.stamp} + {1'b0, e.ttl};
		return (e.ttl != 32'd0) && ({1'b0, now} > limit);
	endfunction

endpackage

// ===== sv/priority_ttl_mailbox_top.sv =====
// Top level of the priority TTL mailbox: controller plus datapath.
//
//  Channel  Handshake            Beat contents
//  input    in_valid / in_ready  req_type .. now_sec, one request
//  output   out_valid/out_ready  status, received message fields, pending
//
// A request passes through accept, slot lookup over all AGENT_SLOTS slots,
// dispatch and finish before the next beat is accepted; broadcast adds a step for
// each slot, and receive for a registered agent adds a walk over the entries from
// head to tail and a final step. Reset clears the slot table and ring pointers at
// once; the message memory is not cleared. A result waits in the output register
// while the next request runs, which then holds in its finish state until taken.
module priority_ttl_mailbox_top #(
	parameter int AGENT_SLOTS = 8,
	parameter int RING_DEPTH  = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  req_type,
	input  logic [63:0] agent_key,
	input  logic [63:0] sender_id,
	input  logic [7:0]  msg_kind,
	input  logic [31:0] payload_ref,
	input  logic [15:0] payload_bytes,
	input  logic [63:0] corr_id,
	input  logic [1:0]  prio,
	input  logic [31:0] ttl,
	input  logic [31:0] now_sec,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [7:0]  out_kind,
	output logic [63:0] out_sender,
	output logic [31:0] out_payload_ref,
	output logic [15:0] out_payload_bytes,
	output logic [31:0] out_stamp,
	output logic [63:0] out_corr_id,
	output logic [1:0]  out_prio,
	output logic [31:0] out_ttl,
	output logic [7:0]  pending
);

	ptm_pkg::op_t    op;
	ptm_pkg::stat_t  st;
	ptm_pkg::entry_t out_msg;

	ptm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.op       (op)
	);

	ptm_dp #(
		.AGENT_SLOTS (AGENT_SLOTS),
		.RING_DEPTH  (RING_DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.op            (op),
		.st            (st),
		.req_type      (req_type),
		.agent_key     (agent_key),
		.sender_id     (sender_id),
		.msg_kind      (msg_kind),
		.payload_ref   (payload_ref),
		.payload_bytes (payload_bytes),
		.corr_id       (corr_id),
		.prio          (prio),
		.ttl           (ttl),
		.now_sec       (now_sec),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.out_msg       (out_msg),
		.pending       (pending)
	);

	// Unpack the received message onto its ports.
	assign out_kind          = out_msg.kind;
	assign out_sender        = out_msg.sender;
	assign out_payload_ref   = out_msg.payload;
	assign out_payload_bytes = out_msg.bytes;
	assign out_stamp         = out_msg.stamp;
	assign out_corr_id       = out_msg.corr;
	assign out_prio          = out_msg.prio;
	assign out_ttl           = out_msg.ttl;

endmodule

// ===== sv/ptm_ctrl.sv =====
// Controller state machine of the priority TTL mailbox.
module ptm_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  ptm_pkg::stat_t st,
	output ptm_pkg::op_t   op
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOOK,
		S_DISPATCH,
		S_BCAST,
		S_RX_SCAN,
		S_RX_FIN,
		S_FIN
	} state_t;

	state_t state_q, state_d;

	// Next state and the operation issued in the current state.
	always_comb begin
		state_d = state_q;
		op = ptm_pkg::OP_IDLE;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op = ptm_pkg::OP_LOAD;
					state_d = S_LOOK;
				end
			end
			S_LOOK: begin
				op = ptm_pkg::OP_SLOT_SCAN;
				if (st.scan_last) state_d = S_DISPATCH;
			end
			S_DISPATCH: begin
				state_d = S_FIN;
				unique case (st.req)
					ptm_pkg::REQ_REG:   op = ptm_pkg::OP_REG;
					ptm_pkg::REQ_UNREG: op = ptm_pkg::OP_UNREG;
					ptm_pkg::REQ_SEND:  op = ptm_pkg::OP_SEND;
					ptm_pkg::REQ_COUNT: op = ptm_pkg::OP_COUNT;
					ptm_pkg::REQ_BCAST: begin
						op = ptm_pkg::OP_IDLE;
						state_d = S_BCAST;
					end
					ptm_pkg::REQ_RECV: begin
						if (st.found) begin
							op = ptm_pkg::OP_RX_START;
							state_d = S_RX_SCAN;
						end else begin
							op = ptm_pkg::OP_BAD;
						end
					end
					default: op = ptm_pkg::OP_BAD;
				endcase
			end
			S_BCAST: begin
				op = ptm_pkg::OP_BCAST_STEP;
				if (st.scan_last) state_d = S_FIN;
			end
			S_RX_SCAN: begin
				op = ptm_pkg::OP_RX_STEP;
				if (st.rx_done) state_d = S_RX_FIN;
			end
			S_RX_FIN: begin
				op = ptm_pkg::OP_RX_FIN;
				state_d = S_FIN;
			end
			S_FIN: begin
				if (!st.out_busy) begin
					op = ptm_pkg::OP_FINISH;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign in_ready = (state_q == S_IDLE);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== sv/ptm_dp.sv =====
// Datapath of the priority TTL mailbox: slot table, ring pointers, message memory.
module ptm_dp #(
	parameter int AGENT_SLOTS = 8,
	parameter int RING_DEPTH  = 256
) (
	input  logic           clk,
	input  logic           arst_n,
	input  ptm_pkg::op_t   op,
	output ptm_pkg::stat_t st,
	input  logic [2:0]     req_type,
	input  logic [63:0]    agent_key,
	input  logic [63:0]    sender_id,
	input  logic [7:0]     msg_kind,
	input  logic [31:0]    payload_ref,
	input  logic [15:0]    payload_bytes,
	input  logic [63:0]    corr_id,
	input  logic [1:0]     prio,
	input  logic [31:0]    ttl,
	input  logic [31:0]    now_sec,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [1:0]     status,
	output ptm_pkg::entry_t out_msg,
	output logic [7:0]     pending
);

	localparam int SW    = (AGENT_SLOTS > 1) ? $clog2(AGENT_SLOTS) : 1;
	localparam int PW    = $clog2(RING_DEPTH);
	localparam int CW    = PW + 1;
	localparam int DEPTH = AGENT_SLOTS * RING_DEPTH;
	localparam int AW    = $clog2(DEPTH);

	// Latched request.
	logic [2:0]  req_q;
	logic [63:0] agent_q, sender_q, corr_q;
	logic [7:0]  kind_q;
	logic [31:0] pay_q, ttl_q, now_q;
	logic [15:0] bytes_q;
	logic [1:0]  prio_q;

	// Slot table and ring pointers.
	logic            used_q  [AGENT_SLOTS];
	logic [63:0]     owner_q [AGENT_SLOTS];
	logic [PW-1:0]   head_q  [AGENT_SLOTS];
	logic [PW-1:0]   tail_q  [AGENT_SLOTS];

	// Lookup results.
	logic [SW-1:0]   sidx_q, slot_q, free_q;
	logic            found_q, free_ok_q;

	// Receive scan state.
	logic [PW-1:0]   rp_q, chk_q, best_q;
	logic [1:0]      top_prio_q;
	logic            pend_q, drop_q, rx_ok_q;
	ptm_pkg::entry_t h_data_q, best_data_q;

	// Message memory.
	ptm_pkg::entry_t mem [DEPTH];
	ptm_pkg::entry_t rdata_q;
	logic            wr_en, rd_en;
	logic [AW-1:0]   waddr, raddr;
	ptm_pkg::entry_t wdata;

	logic [1:0]      status_q;
	logic [1:0]      res_status_q;
	logic            out_valid_q;
	ptm_pkg::entry_t out_msg_q;
	logic [7:0]      pending_q;

	function automatic logic [PW-1:0] next_pos(input logic [PW-1:0] p);
		return (p == PW'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [AW-1:0] addr_of(input logic [SW-1:0] s,
			input logic [PW-1:0] p);
		return AW'(AW'(s) * AW'(RING_DEPTH)) + AW'(p);
	endfunction

	function automatic logic [CW-1:0] ring_count(input logic [PW-1:0] h,
			input logic [PW-1:0] t);
		return (t >= h) ? CW'(t) - CW'(h) : CW'(t) + CW'(RING_DEPTH) - CW'(h);
	endfunction

	logic            scan_last;
	logic [PW-1:0]   cur_head, cur_tail, bc_tail;
	logic            cur_full, bc_full, bc_hit, rd_exp;
	logic [CW-1:0]   cnt;
	ptm_pkg::entry_t new_msg, bc_msg;

	// Decode of the current slot and the message being written.
	always_comb begin
		scan_last = (sidx_q == SW'(AGENT_SLOTS - 1));
		cur_head  = head_q[slot_q];
		cur_tail  = tail_q[slot_q];
		cur_full  = (next_pos(cur_tail) == cur_head);
		bc_tail   = tail_q[sidx_q];
		bc_full   = (next_pos(bc_tail) == head_q[sidx_q]);
		bc_hit    = used_q[sidx_q] && (owner_q[sidx_q] != sender_q) && !bc_full;
		rd_exp    = ptm_pkg::expired(rdata_q, now_q);
		cnt       = ring_count(cur_head, cur_tail);
		new_msg.kind    = kind_q;
		new_msg.sender  = sender_q;
		new_msg.corr    = corr_q;
		new_msg.payload = pay_q;
		new_msg.bytes   = bytes_q;
		new_msg.stamp   = now_q;
		new_msg.prio    = prio_q;
		new_msg.ttl     = ttl_q;
		bc_msg      = new_msg;
		bc_msg.corr = 64'd0;
		bc_msg.prio = ptm_pkg::PRIO_NORMAL;
		bc_msg.ttl  = 32'd0;
	end

	// Memory port control.
	always_comb begin
		wr_en = 1'b0;
		waddr = addr_of(slot_q, cur_tail);
		wdata = new_msg;
		rd_en = (op == ptm_pkg::OP_RX_STEP) && (rp_q != cur_tail);
		raddr = addr_of(slot_q, rp_q);
		unique case (op)
			ptm_pkg::OP_SEND: begin
				wr_en = found_q && !cur_full;
			end
			ptm_pkg::OP_BCAST_STEP: begin
				wr_en = bc_hit;
				waddr = addr_of(sidx_q, bc_tail);
				wdata = bc_msg;
			end
			ptm_pkg::OP_RX_FIN: begin
				wr_en = !drop_q && (best_q != cur_head);
				waddr = addr_of(slot_q, best_q);
				wdata = h_data_q;
			end
			default: begin
			end
		endcase
	end

	// Message memory, one write and one registered read.
	always_ff @(posedge clk) begin
		if (wr_en) mem[waddr] <= wdata;
		if (rd_en) rdata_q <= mem[raddr];
	end

	// Request latch and payload registers.
	always_ff @(posedge clk) begin
		if (op == ptm_pkg::OP_LOAD) begin
			req_q    <= req_type;
			agent_q  <= agent_key;
			sender_q <= sender_id;
			kind_q   <= msg_kind;
			pay_q    <= payload_ref;
			bytes_q  <= payload_bytes;
			corr_q   <= corr_id;
			prio_q   <= prio;
			ttl_q    <= ttl;
			now_q    <= now_sec;
		end
		if (op == ptm_pkg::OP_REG && !found_q && free_ok_q) owner_q[free_q] <= agent_q;
		if (op == ptm_pkg::OP_RX_STEP && pend_q) begin
			if (drop_q) begin
				if (!rd_exp) begin
					h_data_q    <= rdata_q;
					best_data_q <= rdata_q;
					best_q      <= chk_q;
					top_prio_q  <= rdata_q.prio;
				end
			end else if (!rd_exp && rdata_q.prio > top_prio_q) begin
				best_data_q <= rdata_q;
				best_q      <= chk_q;
				top_prio_q  <= rdata_q.prio;
			end
		end
		if (op == ptm_pkg::OP_RX_STEP && rd_en) chk_q <= rp_q;
		if (op == ptm_pkg::OP_FINISH) begin
			out_msg_q <= rx_ok_q ? best_data_q : '0;
			pending_q <= found_q ? ((32'(cnt) > 32'd255) ? 8'hFF : 8'(cnt)) : 8'd0;
		end
	end

	// Control state: slot table, pointers, lookup and scan flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < AGENT_SLOTS; i++) begin
				used_q[i] <= 1'b0;
				head_q[i] <= '0;
				tail_q[i] <= '0;
			end
			sidx_q       <= '0;
			slot_q       <= '0;
			free_q       <= '0;
			found_q      <= 1'b0;
			free_ok_q    <= 1'b0;
			rp_q         <= '0;
			pend_q       <= 1'b0;
			drop_q       <= 1'b0;
			rx_ok_q      <= 1'b0;
			status_q     <= ptm_pkg::ST_MISS;
			res_status_q <= ptm_pkg::ST_MISS;
			out_valid_q  <= 1'b0;
		end else begin
			// A new result beat replaces the one being taken in the same cycle.
			if (op == ptm_pkg::OP_FINISH) out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			unique case (op)
				ptm_pkg::OP_LOAD: begin
					sidx_q    <= '0;
					found_q   <= 1'b0;
					free_ok_q <= 1'b0;
					rx_ok_q   <= 1'b0;
				end
				ptm_pkg::OP_SLOT_SCAN: begin
					if (used_q[sidx_q] && owner_q[sidx_q] == agent_q && !found_q) begin
						found_q <= 1'b1;
						slot_q  <= sidx_q;
					end
					if (!used_q[sidx_q] && !free_ok_q) begin
						free_ok_q <= 1'b1;
						free_q    <= sidx_q;
					end
					sidx_q <= scan_last ? '0 : sidx_q + 1'b1;
				end
				ptm_pkg::OP_REG: begin
					if (found_q) begin
						status_q <= ptm_pkg::ST_OK;
					end else if (free_ok_q) begin
						used_q[free_q] <= 1'b1;
						head_q[free_q] <= '0;
						tail_q[free_q] <= '0;
						found_q        <= 1'b1;
						slot_q         <= free_q;
						status_q       <= ptm_pkg::ST_OK;
					end else begin
						status_q <= ptm_pkg::ST_FULL;
					end
				end
				ptm_pkg::OP_UNREG: begin
					if (found_q) begin
						head_q[slot_q] <= cur_tail;
						used_q[slot_q] <= 1'b0;
						found_q        <= 1'b0;
						status_q       <= ptm_pkg::ST_OK;
					end else begin
						status_q <= ptm_pkg::ST_MISS;
					end
				end
				ptm_pkg::OP_SEND: begin
					if (!found_q) begin
						status_q <= ptm_pkg::ST_MISS;
					end else if (cur_full) begin
						status_q <= ptm_pkg::ST_FULL;
					end else begin
						tail_q[slot_q] <= next_pos(cur_tail);
						status_q       <= ptm_pkg::ST_OK;
					end
				end
				ptm_pkg::OP_COUNT: begin
					status_q <= found_q ? ptm_pkg::ST_OK : ptm_pkg::ST_MISS;
				end
				ptm_pkg::OP_BAD: begin
					status_q <= ptm_pkg::ST_MISS;
				end
				ptm_pkg::OP_BCAST_STEP: begin
					if (bc_hit) tail_q[sidx_q] <= next_pos(bc_tail);
					sidx_q   <= scan_last ? '0 : sidx_q + 1'b1;
					status_q <= ptm_pkg::ST_OK;
				end
				ptm_pkg::OP_RX_START: begin
					rp_q   <= cur_head;
					pend_q <= 1'b0;
					drop_q <= 1'b1;
				end
				ptm_pkg::OP_RX_STEP: begin
					// Evaluate the beat read last cycle, then issue the next read.
					if (pend_q && drop_q) begin
						if (rd_exp) head_q[slot_q] <= next_pos(cur_head);
						else drop_q <= 1'b0;
					end
					if (rd_en) begin
						pend_q <= 1'b1;
						rp_q   <= next_pos(rp_q);
					end else begin
						pend_q <= 1'b0;
					end
				end
				ptm_pkg::OP_RX_FIN: begin
					if (drop_q) begin
						status_q <= ptm_pkg::ST_MISS;
					end else begin
						head_q[slot_q] <= next_pos(cur_head);
						rx_ok_q        <= 1'b1;
						status_q       <= ptm_pkg::ST_OK;
					end
				end
				ptm_pkg::OP_FINISH: begin
					res_status_q <= status_q;
				end
				default: begin
				end
			endcase
		end
	end

	// Status toward the controller and result ports.
	always_comb begin
		st.req       = req_q;
		st.found     = found_q;
		st.scan_last = scan_last;
		st.rx_done   = !pend_q && (rp_q == cur_tail);
		st.out_busy  = out_valid_q && !out_ready;
	end

	assign out_valid = out_valid_q;
	assign status    = res_status_q;
	assign out_msg   = out_msg_q;
	assign pending   = pending_q;

endmodule

// ===== tb/priority_ttl_mailbox_top_tb.sv =====
// Testbench for the priority TTL mailbox: directed and random requests checked against a behavioral predictor.
`timescale 1ns / 1ps

module priority_ttl_mailbox_top_tb;

	localparam int SLOTS = 8;
	localparam int DEPTH = 256;
	localparam int N_RANDOM = 1100;
	localparam longint CYCLE_LIMIT = 3000000;

	// One result beat as seen on the output channel.
	typedef struct {
		logic [1:0]  status;
		logic [7:0]  kind;
		logic [63:0] sender;
		logic [31:0] payload;
		logic [15:0] bytes;
		logic [31:0] stamp;
		logic [63:0] corr;
		logic [1:0]  prio;
		logic [31:0] ttl;
		logic [7:0]  pending;
	} reply_t;

	// One request beat as driven on the input channel.
	typedef struct {
		logic [2:0]  req;
		logic [63:0] agent;
		logic [63:0] sender;
		logic [7:0]  kind;
		logic [31:0] payload;
		logic [15:0] bytes;
		logic [63:0] corr;
		logic [1:0]  prio;
		logic [31:0] ttl;
		logic [31:0] now;
	} request_t;

	// Mailbox predictor with its queue of expected replies.
	class mailbox_scoreboard;
		bit              used [SLOTS];
		logic [63:0]     owner [SLOTS];
		int              head [SLOTS];
		int              tail [SLOTS];
		ptm_pkg::entry_t mem [SLOTS][DEPTH];
		reply_t          expected_replies [$];
		int              errors;

		function int lookup(logic [63:0] id);
			for (int i = 0; i < SLOTS; i++)
				if (used[i] && owner[i] == id)
					return i;
			return -1;
		endfunction

		function bit stale(ptm_pkg::entry_t e, logic [31:0] now);
			return e.ttl != 0 && {1'b0, now} > ({1'b0, e.stamp} + {1'b0, e.ttl});
		endfunction

		function logic [1:0] append(int s, ptm_pkg::entry_t e);
			if ((tail[s] + 1) % DEPTH == head[s])
				return ptm_pkg::ST_FULL;
			mem[s][tail[s]] = e;
			tail[s] = (tail[s] + 1) % DEPTH;
			return ptm_pkg::ST_OK;
		endfunction

		function int fill(int s);
			return (tail[s] + DEPTH - head[s]) % DEPTH;
		endfunction

		// Note an accepted request and queue the reply it should produce.
		function void note_request(request_t q);
			reply_t r;
			ptm_pkg::entry_t e;
			ptm_pkg::entry_t t;
			int s;
			int best;
			int top_prio;
			int cnt;
			r = '{default: '0};
			r.status = ptm_pkg::ST_MISS;
			s = lookup(q.agent);
			case (q.req)
			ptm_pkg::REQ_REG: begin
				if (s >= 0) begin
					r.status = ptm_pkg::ST_OK;
				end else begin
					r.status = ptm_pkg::ST_FULL;
					for (int i = 0; i < SLOTS; i++)
						if (!used[i]) begin
							used[i] = 1; owner[i] = q.agent;
							head[i] = 0; tail[i] = 0;
							r.status = ptm_pkg::ST_OK;
							break;
						end
				end
			end
			ptm_pkg::REQ_UNREG: begin
				if (s >= 0) begin
					head[s] = tail[s]; used[s] = 0; r.status = ptm_pkg::ST_OK;
				end
			end
			ptm_pkg::REQ_SEND: begin
				if (s >= 0) begin
					e = '{q.kind, q.sender, q.corr, q.payload, q.bytes, q.now, q.prio, q.ttl};
					r.status = append(s, e);
				end
			end
			ptm_pkg::REQ_RECV: begin
				if (s >= 0) begin
					while (head[s] != tail[s] && stale(mem[s][head[s]], q.now))
						head[s] = (head[s] + 1) % DEPTH;
					if (head[s] != tail[s]) begin
						best = head[s];
						top_prio = -1;
						for (int i = head[s]; i != tail[s]; i = (i + 1) % DEPTH)
							if (!stale(mem[s][i], q.now) && int'(mem[s][i].prio) > top_prio) begin
								top_prio = mem[s][i].prio;
								best = i;
							end
						t = mem[s][best];
						mem[s][best] = mem[s][head[s]];
						mem[s][head[s]] = t;
						r.status = ptm_pkg::ST_OK;
						r.kind = t.kind; r.sender = t.sender; r.payload = t.payload;
						r.bytes = t.bytes; r.stamp = t.stamp; r.corr = t.corr;
						r.prio = t.prio; r.ttl = t.ttl;
						head[s] = (head[s] + 1) % DEPTH;
					end
				end
			end
			ptm_pkg::REQ_BCAST: begin
				e = '{q.kind, q.sender, 64'd0, q.payload, q.bytes, q.now,
					ptm_pkg::PRIO_NORMAL, 32'd0};
				for (int i = 0; i < SLOTS; i++)
					if (used[i] && owner[i] != q.sender)
						void'(append(i, e));
				r.status = ptm_pkg::ST_OK;
			end
			ptm_pkg::REQ_COUNT: r.status = (s >= 0) ? ptm_pkg::ST_OK : ptm_pkg::ST_MISS;
			default: r.status = ptm_pkg::ST_MISS;
			endcase
			s = lookup(q.agent);
			cnt = (s >= 0) ? fill(s) : 0;
			r.pending = (cnt > 255) ? 8'd255 : cnt[7:0];
			expected_replies.push_back(r);
		endfunction

		function void field(string name, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				errors++;
			end
		endfunction

		// Compare one reply beat with the oldest expectation.
		function void check_reply(reply_t a);
			reply_t x;
			if (expected_replies.size() == 0) begin
				$error("reply beat with nothing expected");
				errors++;
				return;
			end
			x = expected_replies.pop_front();
			field("status", x.status, a.status);
			field("out_kind", x.kind, a.kind);
			field("out_sender", x.sender, a.sender);
			field("out_payload_ref", x.payload, a.payload);
			field("out_payload_bytes", x.bytes, a.bytes);
			field("out_stamp", x.stamp, a.stamp);
			field("out_corr_id", x.corr, a.corr);
			field("out_prio", x.prio, a.prio);
			field("out_ttl", x.ttl, a.ttl);
			field("pending", x.pending, a.pending);
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [2:0]  req_type;
	logic [63:0] agent_key;
	logic [63:0] sender_id;
	logic [7:0]  msg_kind;
	logic [31:0] payload_ref;
	logic [15:0] payload_bytes;
	logic [63:0] corr_id;
	logic [1:0]  prio;
	logic [31:0] ttl;
	logic [31:0] now_sec;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  status;
	logic [7:0]  out_kind;
	logic [63:0] out_sender;
	logic [31:0] out_payload_ref;
	logic [15:0] out_payload_bytes;
	logic [31:0] out_stamp;
	logic [63:0] out_corr_id;
	logic [1:0]  out_prio;
	logic [31:0] out_ttl;
	logic [7:0]  pending;

	mailbox_scoreboard board;
	bit          quiet_phase;
	bit          long_hold;
	longint      cycles = 0;
	logic [63:0] agents [10];
	logic [31:0] clock_sec;

	priority_ttl_mailbox_top #(.AGENT_SLOTS(SLOTS), .RING_DEPTH(DEPTH)) DUT (.*);

	// Free-running clock.
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Cycle watchdog.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Sample reply beats on the clock edge where they are accepted.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_reply('{status, out_kind, out_sender, out_payload_ref,
				out_payload_bytes, out_stamp, out_corr_id, out_prio, out_ttl, pending});
	end

	// Receiver: random stall bursts, one long hold-off, none at the end.
	initial begin
		int gap;
		bit hold_done;
		hold_done = 0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold && !hold_done) begin
				out_ready <= 1'b0;
				repeat (3000) @(posedge clk);
				hold_done = 1;
				out_ready <= 1'b1;
			end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
				gap = $urandom_range(1, 8);
				out_ready <= 1'b0;
				repeat (gap - 1) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Drive one request beat and wait for its acceptance.
	task automatic offer(request_t q);
		int gap;
		if (!quiet_phase && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 8);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= q.req; agent_key <= q.agent; sender_id <= q.sender;
		msg_kind <= q.kind; payload_ref <= q.payload; payload_bytes <= q.bytes;
		corr_id <= q.corr; prio <= q.prio; ttl <= q.ttl; now_sec <= q.now;
		do
			@(posedge clk);
		while (!in_ready);
		board.note_request(q);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Random request, weighted toward a small pool of agents and live traffic.
	function automatic request_t make_request(bit full_ring_bias);
		request_t q;
		int pick;
		q.agent = agents[$urandom_range(0, 9)];
		q.sender = ($urandom_range(0, 3) == 0) ? rand64() : agents[$urandom_range(0, 9)];
		q.kind = 8'($urandom); q.payload = $urandom; q.bytes = 16'($urandom);
		q.corr = rand64(); q.prio = 2'($urandom);
		case ($urandom_range(0, 3))
		0: q.ttl = 0;
		1: q.ttl = $urandom_range(1, 20);
		2: q.ttl = 32'hFFFF_FFFF;
		default: q.ttl = $urandom;
		endcase
		clock_sec = clock_sec + $urandom_range(0, 3);
		q.now = ($urandom_range(0, 30) == 0) ? $urandom : clock_sec;
		pick = $urandom_range(0, 99);
		if (full_ring_bias)
			q.req = (pick < 85) ? ptm_pkg::REQ_SEND : ptm_pkg::REQ_BCAST;
		else if (pick < 8) q.req = ptm_pkg::REQ_REG;
		else if (pick < 12) q.req = ptm_pkg::REQ_UNREG;
		else if (pick < 50) q.req = ptm_pkg::REQ_SEND;
		else if (pick < 80) q.req = ptm_pkg::REQ_RECV;
		else if (pick < 88) q.req = ptm_pkg::REQ_BCAST;
		else if (pick < 96) q.req = ptm_pkg::REQ_COUNT;
		else q.req = 3'($urandom_range(6, 7));
		return q;
	endfunction

	// Main stimulus.
	initial begin
		request_t q;
		int drain;
		board = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = '0; agent_key = '0; sender_id = '0; msg_kind = '0;
		payload_ref = '0; payload_bytes = '0; corr_id = '0; prio = '0;
		ttl = '0; now_sec = '0;
		quiet_phase = 0; long_hold = 0;
		clock_sec = 32'd100;
		agents[0] = 64'd0;
		agents[1] = 64'hFFFF_FFFF_FFFF_FFFF;
		for (int i = 2; i < 10; i++)
			agents[i] = rand64();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: misses, register extremes, priority, expiry, overflow of slots.
		q = '{default: '0};
		q.req = ptm_pkg::REQ_RECV; q.agent = agents[1]; offer(q);
		q.req = ptm_pkg::REQ_UNREG; offer(q);
		q.req = ptm_pkg::REQ_SEND; offer(q);
		q.req = ptm_pkg::REQ_COUNT; offer(q);
		q.req = 3'd6; offer(q);
		q.req = 3'd7; offer(q);
		for (int i = 0; i < 9; i++) begin
			q.req = ptm_pkg::REQ_REG; q.agent = agents[i]; offer(q);
		end
		q.req = ptm_pkg::REQ_REG; q.agent = agents[0]; offer(q);
		q = '{ptm_pkg::REQ_SEND, agents[1], agents[0], 8'hFF, 32'hFFFF_FFFF, 16'hFFFF,
			64'hFFFF_FFFF_FFFF_FFFF, 2'd0, 32'd5, 32'd10};
		offer(q);
		q.prio = 2'd3; q.ttl = 32'hFFFF_FFFF; q.now = 32'hFFFF_FFFF; offer(q);
		q.prio = 2'd2; q.ttl = 0; q.now = 32'd11; offer(q);
		q.req = ptm_pkg::REQ_RECV; q.now = 32'd16; offer(q);
		q.now = 32'd17; offer(q);
		offer(q);
		offer(q);
		q = '{ptm_pkg::REQ_BCAST, agents[0], agents[2], 8'h5A, 32'd1, 16'd2, 64'd0,
			2'd0, 32'd0, 32'd20};
		offer(q);
		q.req = ptm_pkg::REQ_UNREG; q.agent = agents[3]; offer(q);
		q.req = ptm_pkg::REQ_COUNT; q.agent = agents[4]; offer(q);

		// Push rings toward full with 300 sends and broadcasts, keeping results flowing.
		for (int i = 0; i < 300; i++) begin
			q = make_request(1);
			q.agent = agents[1];
			offer(q);
		end

		// Sender pause until every reply has arrived.
		in_valid <= 1'b0;
		while (board.expected_replies.size() != 0)
			@(posedge clk);
		@(posedge clk);

		// Receiver hold-off while requests keep coming.
		long_hold = 1;
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM - 200)
				quiet_phase = 1;
			q = make_request(0);
			if ($urandom_range(0, 30) == 0)
				q.agent = rand64();
			offer(q);
		end
		in_valid <= 1'b0;

		drain = 0;
		while (board.expected_replies.size() != 0 && drain < 200000) begin
			@(posedge clk);
			drain++;
		end
		repeat (600) @(posedge clk);
		if (board.errors == 0 && board.expected_replies.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
